@@ rtl/core/tbpf_pkg.sv @@
// Shared types and constants of the tiled background pixel fetch block.
package tbpf_pkg;

    // Store sizes in halfwords
    localparam int unsigned VIDEO_HALFWORDS = 49152;
    localparam int unsigned PAL_ENTRIES     = 256;
    localparam int unsigned VIDEO_AW        = 16;
    localparam int unsigned PAL_AW          = 8;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_CHAR_BLOCK = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_BLOCK  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_8BPP = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAP_SIZE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_H_SCROLL   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_V_SCROLL   = 3'd5;

    // Input commands
    localparam logic [1:0] CMD_VIDEO_WR = 2'd0;
    localparam logic [1:0] CMD_PAL_WR   = 2'd1;
    localparam logic [1:0] CMD_RENDER   = 2'd2;

    typedef struct packed {
        logic [1:0] char_block;
        logic [4:0] map_block;
        logic       color_8bpp;
        logic [1:0] map_size;
        logic [8:0] h_scroll;
        logic [8:0] v_scroll;
    } cfg_t;

    typedef enum logic [1:0] {
        KIND_VIDEO_WR,
        KIND_PAL_WR,
        KIND_RENDER
    } kind_t;

    // One classified item; addr is the write address or the tilemap halfword address
    typedef struct packed {
        kind_t       kind;
        logic [15:0] addr;
        logic [15:0] data;
        logic [7:0]  column;
        logic [2:0]  px;
        logic [2:0]  py;
    } queue_item_t;

endpackage

@@ rtl/core/tbpf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tbpf_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read in the same cycle as a write to the same entry returns the old data.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/tbpf_front.sv @@
// Front end: classifies accepted items and works out the tilemap address of renders.
module tbpf_front #(
    parameter int unsigned LINE_WIDTH = 240
) (
    input  logic                 [1:0]  cmd,
    input  logic                 [15:0] word_addr,
    input  logic                 [15:0] write_data,
    input  logic                 [7:0]  column,
    input  logic                 [7:0]  line,
    input  tbpf_pkg::cfg_t              cfg,
    output logic                        keep,
    output tbpf_pkg::queue_item_t       item
);

    localparam logic [9:0] LINE_LIMIT = 10'(LINE_WIDTH);

    logic [8:0] sum_x;
    logic [8:0] sum_y;
    logic [8:0] mx;
    logic [8:0] my;
    logic [5:0] tcol;
    logic [5:0] trow;
    logic [1:0] blk;
    logic [5:0] block_base;

    always_comb begin
        sum_x = {1'b0, column} + cfg.h_scroll;
        sum_y = {1'b0, line} + cfg.v_scroll;
        mx    = cfg.map_size[0] ? sum_x : {1'b0, sum_x[7:0]};
        my    = cfg.map_size[1] ? sum_y : {1'b0, sum_y[7:0]};
        tcol  = mx[8:3];
        trow  = my[8:3];
        // Screen blocks run left to right, then top to bottom on a 512-wide map.
        blk        = cfg.map_size[0] ? {trow[5], tcol[5]} : {1'b0, trow[5]};
        block_base = {1'b0, cfg.map_block} + {4'b0000, blk};

        item.data   = write_data;
        item.column = column;
        item.px     = mx[2:0];
        item.py     = my[2:0];
        item.addr   = word_addr;
        item.kind   = tbpf_pkg::KIND_RENDER;
        keep        = 1'b0;

        case (cmd)
            tbpf_pkg::CMD_VIDEO_WR: begin
                item.kind = tbpf_pkg::KIND_VIDEO_WR;
                keep      = ({1'b0, word_addr} < 17'(tbpf_pkg::VIDEO_HALFWORDS));
            end
            tbpf_pkg::CMD_PAL_WR: begin
                item.kind = tbpf_pkg::KIND_PAL_WR;
                keep      = ({1'b0, word_addr} < 17'(tbpf_pkg::PAL_ENTRIES));
            end
            tbpf_pkg::CMD_RENDER: begin
                item.kind = tbpf_pkg::KIND_RENDER;
                item.addr = {block_base, trow[4:0], tcol[4:0]};
                keep      = ({2'b00, column} < LINE_LIMIT);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/tbpf_queue.sv @@
// Short queue of classified items between the front and back ends.
module tbpf_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  tbpf_pkg::queue_item_t        push_item,
    output logic                         full,
    input  logic                         pop,
    output logic                         head_valid,
    output tbpf_pkg::queue_item_t        head_item
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PW    = $clog2(DEPTH);

    tbpf_pkg::queue_item_t slot_reg [DEPTH];
    logic [PW-1:0]         wr_ptr_reg;
    logic [PW-1:0]         rd_ptr_reg;
    logic [PW:0]           count_reg;
    logic [PW:0]           count_next;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full       = (count_reg == (PW+1)'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slot_reg[rd_ptr_reg];

endmodule

@@ rtl/core/tbpf_back.sv @@
// Back end: store writes, tilemap read, tile data read, palette read and result register.
module tbpf_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tbpf_pkg::cfg_t        cfg,
    input  logic                  head_valid,
    input  tbpf_pkg::queue_item_t head_item,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,  // out_column[7:0], pixel_color[23:8]
    output logic                  m_tuser   // opaque
);

    logic advance;
    logic video_we;
    logic pal_issue;
    logic pal_we;
    logic render_issue;

    logic [15:0] map_rdata;
    logic [15:0] tile_rdata;
    logic [15:0] pal_rdata;

    // Stage B: tilemap entry arrives
    logic        b_valid_reg;
    logic [7:0]  b_column_reg;
    logic [2:0]  b_px_reg;
    logic [2:0]  b_py_reg;
    logic        b_pal_we_reg;
    logic [7:0]  b_pal_waddr_reg;
    logic [15:0] b_pal_wdata_reg;

    // Stage C: tile data halfword arrives
    logic        c_valid_reg;
    logic [7:0]  c_column_reg;
    logic        c_sel_reg;
    logic        c_tx0_reg;
    logic [3:0]  c_pal_reg;
    logic        c_pal_we_reg;
    logic [7:0]  c_pal_waddr_reg;
    logic [15:0] c_pal_wdata_reg;

    // Stage D: palette entry arrives
    logic       d_valid_reg;
    logic [7:0] d_column_reg;
    logic       d_zero_reg;

    // Result register
    logic        m_valid_reg;
    logic [7:0]  m_column_reg;
    logic [15:0] m_color_reg;
    logic        m_opaque_reg;

    logic [2:0]  tx;
    logic [2:0]  ty;
    logic [16:0] byte_addr;
    logic [16:0] folded_addr;
    logic [7:0]  byte_val;
    logic [3:0]  nibble;
    logic [7:0]  pal_addr;
    logic        index_zero;

    // The whole back pipeline moves whenever the result register can take an item.
    assign advance      = !m_valid_reg || m_tready;
    assign pop          = head_valid && advance;
    assign video_we     = pop && (head_item.kind == tbpf_pkg::KIND_VIDEO_WR);
    assign pal_issue    = pop && (head_item.kind == tbpf_pkg::KIND_PAL_WR);
    assign render_issue = pop && (head_item.kind == tbpf_pkg::KIND_RENDER);
    // Palette writes travel to the stage that reads the palette, so that they stay in
    // order with the renders around them.
    assign pal_we       = advance && c_pal_we_reg;

    always_comb begin
        tx = map_rdata[10] ? ~b_px_reg : b_px_reg;
        ty = map_rdata[11] ? ~b_py_reg : b_py_reg;
        if (cfg.color_8bpp) begin
            byte_addr = {1'b0, cfg.char_block, 14'd0} + {1'b0, map_rdata[9:0], ty, tx};
        end else begin
            byte_addr = {1'b0, cfg.char_block, 14'd0} + {2'b00, map_rdata[9:0], ty, tx[2:1]};
        end
        // Byte addresses from 0x18000 upwards mirror the range 8000h below.
        folded_addr = byte_addr;
        if (byte_addr[16] && byte_addr[15]) begin
            folded_addr[15] = 1'b0;
        end

        byte_val = c_sel_reg ? tile_rdata[15:8] : tile_rdata[7:0];
        nibble   = c_tx0_reg ? byte_val[7:4] : byte_val[3:0];
        if (cfg.color_8bpp) begin
            pal_addr   = byte_val;
            index_zero = (byte_val == 8'd0);
        end else begin
            pal_addr   = {c_pal_reg, nibble};
            index_zero = (nibble == 4'd0);
        end
    end

    // Two copies of the video store so that the tilemap and tile data reads run together.
    tbpf_ram #(
        .WIDTH(16),
        .DEPTH(tbpf_pkg::VIDEO_HALFWORDS)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (video_we),
        .waddr (head_item.addr),
        .wdata (head_item.data),
        .re    (advance),
        .raddr (head_item.addr),
        .rdata (map_rdata)
    );

    tbpf_ram #(
        .WIDTH(16),
        .DEPTH(tbpf_pkg::VIDEO_HALFWORDS)
    ) u_tile_ram (
        .aclk  (aclk),
        .we    (video_we),
        .waddr (head_item.addr),
        .wdata (head_item.data),
        .re    (advance),
        .raddr (folded_addr[16:1]),
        .rdata (tile_rdata)
    );

    tbpf_ram #(
        .WIDTH(16),
        .DEPTH(tbpf_pkg::PAL_ENTRIES)
    ) u_pal_ram (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (c_pal_waddr_reg),
        .wdata (c_pal_wdata_reg),
        .re    (advance),
        .raddr (pal_addr),
        .rdata (pal_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg  <= 1'b0;
            c_valid_reg  <= 1'b0;
            d_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            b_pal_we_reg <= 1'b0;
            c_pal_we_reg <= 1'b0;
        end else if (advance) begin
            b_valid_reg  <= render_issue;
            c_valid_reg  <= b_valid_reg;
            d_valid_reg  <= c_valid_reg;
            m_valid_reg  <= d_valid_reg;
            b_pal_we_reg <= pal_issue;
            c_pal_we_reg <= b_pal_we_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            b_column_reg    <= head_item.column;
            b_px_reg        <= head_item.px;
            b_py_reg        <= head_item.py;
            b_pal_waddr_reg <= head_item.addr[tbpf_pkg::PAL_AW-1:0];
            b_pal_wdata_reg <= head_item.data;

            c_column_reg    <= b_column_reg;
            c_sel_reg       <= folded_addr[0];
            c_tx0_reg       <= tx[0];
            c_pal_reg       <= map_rdata[15:12];
            c_pal_waddr_reg <= b_pal_waddr_reg;
            c_pal_wdata_reg <= b_pal_wdata_reg;

            d_column_reg <= c_column_reg;
            d_zero_reg   <= index_zero;

            m_column_reg <= d_column_reg;
            m_color_reg  <= d_zero_reg ? 16'd0 : pal_rdata;
            m_opaque_reg <= !d_zero_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_color_reg, m_column_reg};
    assign m_tuser  = m_opaque_reg;

endmodule

@@ rtl/core/tiled_background_pixel_fetch.sv @@
// A render item goes from the queue through stages B, C and D to the result register;
// a stall on m_tready holds the whole back pipeline. Throughput: one item per cycle
// while m_tready does not stall; the store reads run as a three-deep memory pipeline.
// A video write is done as it leaves the queue, a palette write as it leaves stage C.
// Writes and dropped items give no result. Reset (aresetn low, synchronous) clears the
// queue, the pipeline and the registers; video and palette contents are not cleared.
module tiled_background_pixel_fetch #(
    parameter int unsigned LINE_WIDTH = 240
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [tbpf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tbpf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,  // word_addr, write_data, column, line
    input  logic [1:0]                      s_tuser,  // cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,  // out_column, pixel_color
    output logic                            m_tuser   // opaque
);

    tbpf_pkg::cfg_t        cfg_reg;
    tbpf_pkg::queue_item_t front_item;
    tbpf_pkg::queue_item_t head_item;
    logic                  keep;
    logic                  full;
    logic                  head_valid;
    logic                  pop;
    logic                  push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                tbpf_pkg::CFG_CHAR_BLOCK: cfg_reg.char_block <= cfg_wdata[1:0];
                tbpf_pkg::CFG_MAP_BLOCK:  cfg_reg.map_block  <= cfg_wdata[4:0];
                tbpf_pkg::CFG_COLOR_8BPP: cfg_reg.color_8bpp <= cfg_wdata[0];
                tbpf_pkg::CFG_MAP_SIZE:   cfg_reg.map_size   <= cfg_wdata[1:0];
                tbpf_pkg::CFG_H_SCROLL:   cfg_reg.h_scroll   <= cfg_wdata;
                tbpf_pkg::CFG_V_SCROLL:   cfg_reg.v_scroll   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !full;
    assign push     = s_tvalid && s_tready && keep;

    tbpf_front #(
        .LINE_WIDTH(LINE_WIDTH)
    ) u_front (
        .cmd        (s_tuser),
        .word_addr  (s_tdata[15:0]),
        .write_data (s_tdata[31:16]),
        .column     (s_tdata[39:32]),
        .line       (s_tdata[47:40]),
        .cfg        (cfg_reg),
        .keep       (keep),
        .item       (front_item)
    );

    tbpf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (front_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    tbpf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

@@ verif/tiled_background_pixel_fetch_tb.sv @@
// Self-checking testbench for the tiled background pixel fetch block.
module tiled_background_pixel_fetch_tb;

    localparam int unsigned LINE_WIDTH       = 240;
    localparam int unsigned MIRROR_START     = 'h18000;
    localparam int unsigned MIRROR_STEP      = 'h8000;
    localparam int unsigned MAP_BLOCK_BYTES  = 'h800;
    localparam int unsigned CHAR_BLOCK_BYTES = 'h4000;
    localparam logic [1:0]  CMD_UNUSED       = 2'd3;
    localparam int          CFG_BITS         = $bits(tbpf_pkg::cfg_t);

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int DRAIN_CYCLES    = 8;
    localparam int LONG_HOLD       = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_PRINTED     = 40;

    typedef struct packed {
        logic [7:0]  column;
        logic [15:0] colour;
        logic        opaque;
    } pixel_t;

    class pixel_scoreboard;
        bit [15:0]      video_mem [tbpf_pkg::VIDEO_HALFWORDS];
        bit [15:0]      palette_mem [tbpf_pkg::PAL_ENTRIES];
        bit             video_written [tbpf_pkg::VIDEO_HALFWORDS];
        bit             palette_written [tbpf_pkg::PAL_ENTRIES];
        tbpf_pkg::cfg_t regs = '0;
        pixel_t         pending [$];
        int             mismatches = 0;
        int             items_in = 0;
        int             pixels_checked = 0;

        task report(input string msg);
            if (mismatches < MAX_PRINTED) $display("[%0t] %s", $realtime, msg);
            mismatches++;
        endtask

        function void note_config(input logic [tbpf_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [tbpf_pkg::CFG_DATA_W-1:0] value);
            case (index)
                tbpf_pkg::CFG_CHAR_BLOCK: regs.char_block = value[1:0];
                tbpf_pkg::CFG_MAP_BLOCK:  regs.map_block  = value[4:0];
                tbpf_pkg::CFG_COLOR_8BPP: regs.color_8bpp = value[0];
                tbpf_pkg::CFG_MAP_SIZE:   regs.map_size   = value[1:0];
                tbpf_pkg::CFG_H_SCROLL:   regs.h_scroll   = value[8:0];
                tbpf_pkg::CFG_V_SCROLL:   regs.v_scroll   = value[8:0];
                default: ;
            endcase
        endfunction

        // Byte addresses from 0x18000 upwards alias the upper 32 KB of tile memory.
        function int unsigned fold(input int unsigned byte_addr);
            if (byte_addr >= MIRROR_START) byte_addr -= MIRROR_STEP;
            return byte_addr;
        endfunction

        function bit [7:0] video_byte(input int unsigned byte_addr);
            bit [15:0] h;
            h = video_mem[fold(byte_addr) >> 1];
            return byte_addr[0] ? h[15:8] : h[7:0];
        endfunction

        // Finds the map entry halfword, the tile byte, the palette entry and the colour
        // index of one pixel from the present store contents.
        function void locate(input logic [7:0] col, input logic [7:0] ln,
                             output int unsigned map_half, output int unsigned tile_byte,
                             output int unsigned pal_index, output int unsigned idx);
            int unsigned mx, my, tcol, trow, px, py, tx, ty, blk, map_byte, tile_base;
            bit [15:0]   entry;
            bit [7:0]    bits;
            mx = (col + regs.h_scroll) & (regs.map_size[0] ? 'h1FF : 'hFF);
            my = (ln + regs.v_scroll) & (regs.map_size[1] ? 'h1FF : 'hFF);
            tcol = mx >> 3;
            trow = my >> 3;
            px = mx & 7;
            py = my & 7;
            // Wide maps place the right-hand screen block next to the left one.
            blk = (trow >> 5) * (regs.map_size[0] ? 2 : 1) + (tcol >> 5);
            map_byte = regs.map_block * MAP_BLOCK_BYTES + blk * MAP_BLOCK_BYTES
                     + ((trow % 32) * 32 + tcol % 32) * 2;
            map_half = fold(map_byte) >> 1;
            entry = video_mem[map_half];
            tx = entry[10] ? 7 - px : px;
            ty = entry[11] ? 7 - py : py;
            tile_base = regs.char_block * CHAR_BLOCK_BYTES;
            if (!regs.color_8bpp) begin
                tile_byte = tile_base + entry[9:0] * 32 + ty * 4 + tx / 2;
                bits = video_byte(tile_byte);
                idx = tx[0] ? bits[7:4] : bits[3:0];
                pal_index = (entry[15:12] * 16 + idx) & 'hFF;
            end else begin
                tile_byte = tile_base + entry[9:0] * 64 + ty * 8 + tx;
                idx = video_byte(tile_byte);
                pal_index = idx;
            end
        endfunction

        function pixel_t fetch_pixel(input logic [7:0] col, input logic [7:0] ln);
            int unsigned map_half, tile_byte, pal_index, idx;
            pixel_t      res;
            locate(col, ln, map_half, tile_byte, pal_index, idx);
            res.column = col;
            res.opaque = (idx != 0);
            res.colour = res.opaque ? palette_mem[pal_index] : '0;
            return res;
        endfunction

        // Gives the first store entry that a render would read before it was written.
        function bit first_unwritten(input logic [7:0] col, input logic [7:0] ln,
                                     output bit to_pal, output logic [15:0] addr);
            int unsigned map_half, tile_byte, pal_index, idx, tile_half;
            locate(col, ln, map_half, tile_byte, pal_index, idx);
            tile_half = fold(tile_byte) >> 1;
            to_pal = 1'b0;
            addr = 16'(map_half);
            if (!video_written[map_half]) return 1'b1;
            addr = 16'(tile_half);
            if (!video_written[tile_half]) return 1'b1;
            to_pal = 1'b1;
            addr = 16'(pal_index);
            return !palette_written[pal_index];
        endfunction

        function void note_item(input logic [1:0] cmd, input logic [15:0] addr,
                                input logic [15:0] data, input logic [7:0] col,
                                input logic [7:0] ln);
            items_in++;
            case (cmd)
                tbpf_pkg::CMD_VIDEO_WR:
                    if (addr < tbpf_pkg::VIDEO_HALFWORDS) begin
                        video_mem[addr] = data;
                        video_written[addr] = 1'b1;
                    end
                tbpf_pkg::CMD_PAL_WR:
                    if (addr < tbpf_pkg::PAL_ENTRIES) begin
                        palette_mem[addr[7:0]] = data;
                        palette_written[addr[7:0]] = 1'b1;
                    end
                tbpf_pkg::CMD_RENDER:
                    if (col < LINE_WIDTH) pending.push_back(fetch_pixel(col, ln));
                default: ;
            endcase
        endfunction

        task check_result(input logic [7:0] col, input logic [15:0] colour,
                          input logic opaque);
            pixel_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected pixel for column %0d", col));
                return;
            end
            want = pending.pop_front();
            pixels_checked++;
            if (col !== want.column)
                report($sformatf("column: got %0d, want %0d", col, want.column));
            if (colour !== want.colour)
                report($sformatf("colour at column %0d: got %h, want %h",
                                 want.column, colour, want.colour));
            if (opaque !== want.opaque)
                report($sformatf("opaque at column %0d: got %b, want %b",
                                 want.column, opaque, want.opaque));
        endtask
    endclass

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [tbpf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [tbpf_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [47:0]                      s_tdata   = '0;  // word_addr, write_data, column, line
    logic [1:0]                       s_tuser   = '0;  // cmd
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [23:0]                      m_tdata;         // out_column, pixel_color
    logic                             m_tuser;         // opaque

    pixel_scoreboard board = new;
    bit sender_idle   = 1'b0;
    bit sink_idle     = 1'b0;
    bit long_hold_req = 1'b0;

    tiled_background_pixel_fetch #(
        .LINE_WIDTH(LINE_WIDTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic drive_item(input logic [1:0] cmd, input logic [15:0] addr,
                              input logic [15:0] data, input logic [7:0] col,
                              input logic [7:0] ln);
        int gap;
        gap = sender_idle ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {ln, col, data, addr};
        do @(posedge aclk); while (!s_tready);
        board.note_item(cmd, addr, data, col, ln);
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] addr,
                             input logic [15:0] data, input logic [7:0] col,
                             input logic [7:0] ln);
        bit          to_pal;
        logic [15:0] fill_addr;
        if (cmd == tbpf_pkg::CMD_RENDER && col < LINE_WIDTH) begin
            // Every store entry that the render reads is written before it.
            while (board.first_unwritten(col, ln, to_pal, fill_addr))
                drive_item(to_pal ? tbpf_pkg::CMD_PAL_WR : tbpf_pkg::CMD_VIDEO_WR,
                           fill_addr, 16'($urandom), 8'd0, 8'd0);
        end
        drive_item(cmd, addr, data, col, ln);
    endtask

    task automatic send_random_item();
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [7:0]  col;
        int          r;
        r = $urandom_range(99);
        if (r < 68)      cmd = tbpf_pkg::CMD_RENDER;
        else if (r < 84) cmd = tbpf_pkg::CMD_VIDEO_WR;
        else if (r < 95) cmd = tbpf_pkg::CMD_PAL_WR;
        else             cmd = CMD_UNUSED;
        addr = 16'($urandom);
        if (cmd == tbpf_pkg::CMD_VIDEO_WR && $urandom_range(9) != 0)
            addr = 16'($urandom_range(tbpf_pkg::VIDEO_HALFWORDS - 1));
        if (cmd == tbpf_pkg::CMD_PAL_WR && $urandom_range(6) != 0)
            addr = 16'($urandom_range(tbpf_pkg::PAL_ENTRIES - 1));
        col = ($urandom_range(9) != 0) ? 8'($urandom_range(LINE_WIDTH - 1))
                                        : 8'($urandom_range(LINE_WIDTH, 255));
        send_item(cmd, addr, 16'($urandom), col, 8'($urandom));
    endtask

    task automatic write_regs(input tbpf_pkg::cfg_t setting);
        logic [tbpf_pkg::CFG_INDEX_W-1:0] reg_index [6];
        logic [tbpf_pkg::CFG_DATA_W-1:0]  reg_value [6];
        reg_index = '{tbpf_pkg::CFG_CHAR_BLOCK, tbpf_pkg::CFG_MAP_BLOCK,
                      tbpf_pkg::CFG_COLOR_8BPP, tbpf_pkg::CFG_MAP_SIZE,
                      tbpf_pkg::CFG_H_SCROLL, tbpf_pkg::CFG_V_SCROLL};
        reg_value = '{9'(setting.char_block), 9'(setting.map_block),
                      9'(setting.color_8bpp), 9'(setting.map_size),
                      setting.h_scroll, setting.v_scroll};
        foreach (reg_index[i]) begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_index[i];
            cfg_wdata <= reg_value[i];
            @(posedge aclk);
            board.note_config(reg_index[i], reg_value[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Dropped items leave no trace in the expectations, so allow the pipeline to empty.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : sink
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata[7:0], m_tdata[23:8], m_tuser);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall = LONG_HOLD;
            end else if (stall == 0 && sink_idle) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Timed out: no item moved for %0d cycles", quiet);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        tbpf_pkg::cfg_t setting;
        int             phase_end;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Fill the palette; video entries are written just before the first render
        // that reads them.
        for (int a = 0; a < tbpf_pkg::PAL_ENTRIES; a++)
            send_item(tbpf_pkg::CMD_PAL_WR, 16'(a), 16'($urandom), 8'($urandom),
                      8'($urandom));

        sender_idle = 1'b1;
        sink_idle   = 1'b1;
        // Map entry 0 names tile 0, whose first byte is then zero: a transparent pixel.
        send_item(tbpf_pkg::CMD_VIDEO_WR, 16'd0, 16'h0000, 8'd0, 8'd0);
        send_item(tbpf_pkg::CMD_RENDER, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0);
        send_item(tbpf_pkg::CMD_VIDEO_WR, 16'd1, 16'hF5F5, 8'hFF, 8'hFF);
        send_item(tbpf_pkg::CMD_PAL_WR, 16'd5, 16'hFFFF, 8'd0, 8'd0);
        send_item(tbpf_pkg::CMD_RENDER, 16'd0, 16'd0, 8'd4, 8'd0);
        send_item(tbpf_pkg::CMD_PAL_WR, 16'd0, 16'h0000, 8'd0, 8'd0);
        send_item(tbpf_pkg::CMD_PAL_WR, 16'(tbpf_pkg::PAL_ENTRIES - 1), 16'hFFFF,
                  8'd0, 8'd0);
        send_item(tbpf_pkg::CMD_VIDEO_WR, 16'(tbpf_pkg::VIDEO_HALFWORDS - 1), 16'hFFFF,
                  8'd0, 8'd0);
        send_item(tbpf_pkg::CMD_VIDEO_WR, 16'(tbpf_pkg::VIDEO_HALFWORDS), 16'h1234,
                  8'd0, 8'd0);
        send_item(tbpf_pkg::CMD_VIDEO_WR, 16'hFFFF, 16'hFFFF, 8'd0, 8'd0);
        send_item(tbpf_pkg::CMD_PAL_WR, 16'(tbpf_pkg::PAL_ENTRIES), 16'h4321, 8'd0, 8'd0);
        send_item(tbpf_pkg::CMD_PAL_WR, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 8'd10, 8'd10);
        send_item(tbpf_pkg::CMD_RENDER, 16'd0, 16'd0, 8'(LINE_WIDTH - 1), 8'd255);
        send_item(tbpf_pkg::CMD_RENDER, 16'd0, 16'd0, 8'(LINE_WIDTH), 8'd0);
        send_item(tbpf_pkg::CMD_RENDER, 16'd0, 16'd0, 8'd255, 8'd255);
        send_item(tbpf_pkg::CMD_RENDER, 16'd0, 16'd0, 8'd128, 8'd128);
        // Both flips and the top palette bank on tile 0.
        send_item(tbpf_pkg::CMD_VIDEO_WR, 16'd0, 16'hFC00, 8'd0, 8'd0);
        send_item(tbpf_pkg::CMD_RENDER, 16'd0, 16'd0, 8'd0, 8'd0);
        send_item(tbpf_pkg::CMD_RENDER, 16'd0, 16'd0, 8'd7, 8'd7);
        send_item(tbpf_pkg::CMD_RENDER, 16'd0, 16'd0, 8'd3, 8'd5);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       setting = '0;
                1:       setting = '1;
                default: setting = tbpf_pkg::cfg_t'(CFG_BITS'($urandom));
            endcase
            wait_drained();
            write_regs(setting);
            sender_idle = (ph != 3 && ph != 4);
            sink_idle   = (ph != 3);
            // The receiver holds off for a long stretch while items keep coming.
            if (ph == 4) long_hold_req = 1'b1;
            phase_end = board.items_in + ITEMS_PER_PHASE;
            while (board.items_in < phase_end) send_random_item();
        end

        wait_drained();
        $display("Run covered %0d input items and %0d compared pixels over %0d register settings,",
                 board.items_in, board.pixels_checked, NUM_PHASES);
        $display("including all-zero and all-max settings and a long output back-pressure stall.");
        if (board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
